// ----- rtl/mma_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mma_pkg: shared types and constants for the 4x4 matrix multiply core
// Element format, output user-field layout, sequencer states and the
// control word that drives the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int ELEM_W = 32;
  localparam int IDX_W  = 4;
  localparam int USER_W = IDX_W + 1;

  localparam logic [ELEM_W-1:0] ELEM_MAX = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] ELEM_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    S_LOAD,
    S_ROW,
    S_MAC,
    S_DRAIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
  } mac_ctl_t;

endpackage : mma_pkg
`default_nettype wire

// ----- rtl/mma_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mma_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule : mma_ram
`default_nettype wire

// ----- rtl/mma_mac.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mma_mac: shared multiply-accumulate unit with round and saturate
// Registered 32x32 signed product, full-precision accumulator, then
// round-half-up to the output format and clamp to 32 bits.
// ----------------------------------------------------------------------------
module mma_mac #(
  parameter int MATRIX_DIM    = 4,
  parameter int FRACTION_BITS = 27
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mma_pkg::mac_ctl_t             ctl,
  input  wire logic [mma_pkg::ELEM_W-1:0]    op_a,
  input  wire logic [mma_pkg::ELEM_W-1:0]    op_b,
  output logic                               busy,
  output logic      [mma_pkg::ELEM_W-1:0]    result,
  output logic                               saturated
);

  import mma_pkg::*;

  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = PROD_W + $clog2(MATRIX_DIM);
  localparam logic signed [ACC_W:0] HALF = (ACC_W+1)'(1) << (FRACTION_BITS - 1);

  logic signed [PROD_W-1:0] prod_r;
  logic                     pv_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W:0]    rnd_sum;
  logic signed [ACC_W:0]    rnd_shift;
  logic [ACC_W-ELEM_W+1:0]  rnd_hi;
  logic                     fits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= $signed(op_a) * $signed(op_b);
    end
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  // add half an LSB, then drop the fraction
  always_comb begin
    rnd_sum   = {acc_r[ACC_W-1], acc_r} + HALF;
    rnd_shift = rnd_sum >>> FRACTION_BITS;
    rnd_hi    = rnd_shift[ACC_W:ELEM_W-1];
    fits      = (&rnd_hi) | (~|rnd_hi);
    saturated = ~fits;
    if (fits) begin
      result = rnd_shift[ELEM_W-1:0];
    end else if (rnd_shift[ACC_W]) begin
      result = ELEM_MIN;
    end else begin
      result = ELEM_MAX;
    end
  end

  assign busy = pv_r;

endmodule : mma_mac
`default_nettype wire

// ----- rtl/matrix_4x4_multiply_accumulate_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_4x4_multiply_accumulate_core: running matrix product M = M * R
// Loads R element by element, then rebuilds M on one shared
// multiply-accumulate unit and streams out the new elements.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | slave     | tdata: rotor_element (Q4.27)
//  out_    | master    | tdata: product_element; tuser: element_index, saturated;
//          |           | tlast: last element of the matrix
//
//  Loading takes R element by element; the last element starts the product,
//  which copies each row of M, then for each element issues its products,
//  drains them and emits the word, all on the single multiplier.
//  Reset: M reads as the identity until the first product is written back.
//  in_tready is high only while loading; a stalled out_ word holds the emit
//  step until it is taken.
// ----------------------------------------------------------------------------
module matrix_4x4_multiply_accumulate_core #(
  parameter int MATRIX_DIM    = 4,
  parameter int FRACTION_BITS = 27
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [mma_pkg::ELEM_W-1:0]    in_tdata,   // [31:0] rotor_element
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [mma_pkg::ELEM_W-1:0]    out_tdata,  // [31:0] product_element
  output logic      [mma_pkg::USER_W-1:0]    out_tuser,  // [3:0] element_index, [4] saturated
  output logic                               out_tlast
);

  import mma_pkg::*;

  localparam int CELLS  = MATRIX_DIM * MATRIX_DIM;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int DIM_W  = $clog2(MATRIX_DIM);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] DIM_STEP  = ADDR_W'(MATRIX_DIM);
  localparam logic [DIM_W-1:0]  DIM_LAST  = DIM_W'(MATRIX_DIM - 1);
  localparam logic [ELEM_W-1:0] ONE       = ELEM_W'(64'd1 << FRACTION_BITS);

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   ld_cnt_r, ld_cnt_nxt;
  logic [ADDR_W-1:0]   e_r, e_nxt;
  logic [ADDR_W-1:0]   lptr_r, lptr_nxt;
  logic [DIM_W-1:0]    k_r, k_nxt;
  logic [DIM_W-1:0]    j_r, j_nxt;
  logic [DIM_W-1:0]    c_r, c_nxt;
  logic [DIM_W-1:0]    r_r, r_nxt;
  logic                id_r, id_nxt;

  logic                rv_r, av_r;
  logic [DIM_W-1:0]    kd_r, ja_r;
  logic [ELEM_W-1:0]   row_r [MATRIX_DIM];

  logic                out_tvalid_r;
  logic [ELEM_W-1:0]   out_tdata_r;
  logic [USER_W-1:0]   out_tuser_r;
  logic                out_tlast_r;

  logic                in_fire, emit_fire;
  logic                row_issue, mac_issue;
  logic                ld_we, kp_we;
  logic [ADDR_W-1:0]   kp_raddr;
  logic [ELEM_W-1:0]   kp_rdata, ld_rdata;
  mac_ctl_t            mac_ctl;
  logic                mac_clr;
  logic                mac_busy;
  logic [ELEM_W-1:0]   mac_result;
  logic                mac_sat;

  assign in_tready = (state_r == S_LOAD);
  assign in_fire   = in_tvalid && in_tready;
  assign emit_fire = (state_r == S_EMIT) && (!out_tvalid_r || out_tready);
  assign kp_raddr  = e_r + ADDR_W'(k_r);

  mma_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_loaded_ram (
    .clk   (clk),
    .we    (ld_we),
    .waddr (ld_cnt_r),
    .wdata (in_tdata),
    .raddr (lptr_r),
    .rdata (ld_rdata)
  );

  mma_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_kept_ram (
    .clk   (clk),
    .we    (kp_we),
    .waddr (e_r),
    .wdata (mac_result),
    .raddr (kp_raddr),
    .rdata (kp_rdata)
  );

  // mul_en, acc_clr
  assign mac_ctl = {av_r, mac_clr};

  mma_mac #(.MATRIX_DIM(MATRIX_DIM), .FRACTION_BITS(FRACTION_BITS)) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mac_ctl),
    .op_a      (row_r[ja_r]),
    .op_b      (ld_rdata),
    .busy      (mac_busy),
    .result    (mac_result),
    .saturated (mac_sat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_fire && ld_cnt_r == LAST_CELL) state_nxt = S_ROW;
      end
      S_ROW: begin
        if (k_r == DIM_LAST) state_nxt = S_MAC;
      end
      S_MAC: begin
        if (j_r == DIM_LAST) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!av_r && !mac_busy) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_fire) begin
          if (e_r == LAST_CELL) state_nxt = S_LOAD;
          else if (c_r == DIM_LAST) state_nxt = S_ROW;
          else state_nxt = S_MAC;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // sequencer outputs and counters
  always_comb begin
    ld_cnt_nxt = ld_cnt_r;
    e_nxt      = e_r;
    lptr_nxt   = lptr_r;
    k_nxt      = k_r;
    j_nxt      = j_r;
    c_nxt      = c_r;
    r_nxt      = r_r;
    id_nxt     = id_r;
    ld_we      = 1'b0;
    kp_we      = 1'b0;
    row_issue  = 1'b0;
    mac_issue  = 1'b0;
    mac_clr    = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          ld_we      = 1'b1;
          ld_cnt_nxt = (ld_cnt_r == LAST_CELL) ? '0 : ld_cnt_r + 1'b1;
        end
      end
      S_ROW: begin
        row_issue = 1'b1;
        mac_clr   = 1'b1;
        k_nxt     = (k_r == DIM_LAST) ? '0 : k_r + 1'b1;
        j_nxt     = '0;
        lptr_nxt  = '0;
      end
      S_MAC: begin
        mac_issue = 1'b1;
        j_nxt     = (j_r == DIM_LAST) ? '0 : j_r + 1'b1;
        lptr_nxt  = lptr_r + DIM_STEP;
      end
      S_DRAIN: begin
        // wait for the last product to land in the accumulator
      end
      S_EMIT: begin
        if (emit_fire) begin
          kp_we   = 1'b1;
          mac_clr = 1'b1;
          e_nxt   = (e_r == LAST_CELL) ? '0 : e_r + 1'b1;
          if (e_r == LAST_CELL) id_nxt = 1'b0;
          if (c_r == DIM_LAST) begin
            c_nxt    = '0;
            r_nxt    = (r_r == DIM_LAST) ? '0 : r_r + 1'b1;
            lptr_nxt = '0;
          end else begin
            c_nxt    = c_r + 1'b1;
            lptr_nxt = ADDR_W'(c_r) + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      ld_cnt_r <= '0;
      e_r      <= '0;
      lptr_r   <= '0;
      k_r      <= '0;
      j_r      <= '0;
      c_r      <= '0;
      r_r      <= '0;
      id_r     <= 1'b1;
      rv_r     <= 1'b0;
      av_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ld_cnt_r <= ld_cnt_nxt;
      e_r      <= e_nxt;
      lptr_r   <= lptr_nxt;
      k_r      <= k_nxt;
      j_r      <= j_nxt;
      c_r      <= c_nxt;
      r_r      <= r_nxt;
      id_r     <= id_nxt;
      rv_r     <= row_issue;
      av_r     <= mac_issue;
    end
  end

  // copy the current row of M; before the first write-back M is the identity
  always_ff @(posedge clk) begin
    kd_r <= k_r;
    ja_r <= j_r;
    if (rv_r) begin
      if (id_r) begin
        row_r[kd_r] <= (kd_r == r_r) ? ONE : '0;
      end else begin
        row_r[kd_r] <= kp_rdata;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_tdata_r <= mac_result;
      out_tuser_r <= {mac_sat, IDX_W'(e_r)};
      out_tlast_r <= (e_r == LAST_CELL);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  a_load_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_LOAD |-> ld_cnt_r == '0)
    else $error("load count nonzero outside load phase");

  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> !av_r && !mac_busy)
    else $error("emit with products still in flight");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tlast_r |-> out_tuser_r[IDX_W-1:0] == IDX_W'(CELLS - 1))
    else $error("last word carries wrong element index");

  a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !av_r && !rv_r && !mac_busy)
    else $error("accepting input while product in progress");

endmodule : matrix_4x4_multiply_accumulate_core
`default_nettype wire

// ----- tb/mma_product_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_product_checker: predicts and checks the running 4x4 matrix product
// Mirrors the kept matrix, collects each loaded rotor element from the input
// stream, and on the sixteenth one rebuilds the kept matrix at full precision
// (round half up, saturate to 32 bits). The sixteen predicted words are
// queued and compared field by field against the output stream in order.
// ----------------------------------------------------------------------------
module mma_product_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  input  wire logic                       in_tready,
  input  wire logic [mma_pkg::ELEM_W-1:0] in_tdata,   // [31:0] rotor_element
  input  wire logic                       out_tvalid,
  input  wire logic                       out_tready,
  input  wire logic [mma_pkg::ELEM_W-1:0] out_tdata,  // [31:0] product_element
  input  wire logic [mma_pkg::USER_W-1:0] out_tuser,  // [3:0] element_index, [4] saturated
  input  wire logic                       out_tlast,
  output int                              mismatch_count,
  output int                              outstanding
);

  import mma_pkg::*;

  localparam int DIM   = 4;
  localparam int CELLS = DIM * DIM;
  localparam int FRAC  = 27;

  localparam logic signed [71:0] SUM_MAX  = 72'sd2147483647;
  localparam logic signed [71:0] SUM_MIN  = -72'sd2147483648;
  localparam logic signed [71:0] ROUND_UP = 72'sd1 <<< (FRAC - 1);

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic [IDX_W-1:0]  index;
    logic              last;
    logic              saturated;
  } product_word_t;

  logic signed [ELEM_W-1:0] kept_matrix   [CELLS];
  logic signed [ELEM_W-1:0] rotor_matrix  [CELLS];
  int                       rotor_count;
  product_word_t            pending_products [$];

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
  end

  // M = M * R; queue the new elements in row-major order
  task automatic rebuild_kept_matrix();
    logic signed [71:0]       acc;
    logic signed [71:0]       lhs;
    logic signed [71:0]       rhs;
    logic signed [71:0]       rounded;
    logic signed [ELEM_W-1:0] fresh [CELLS];
    product_word_t            word;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        acc = '0;
        for (int j = 0; j < DIM; j++) begin
          lhs = kept_matrix[r*DIM + j];
          rhs = rotor_matrix[j*DIM + c];
          acc = acc + lhs * rhs;
        end
        rounded = (acc + ROUND_UP) >>> FRAC;
        word.index     = IDX_W'(r*DIM + c);
        word.last      = (r*DIM + c == CELLS - 1);
        word.saturated = 1'b0;
        if (rounded > SUM_MAX) begin
          word.element   = ELEM_MAX;
          word.saturated = 1'b1;
        end else if (rounded < SUM_MIN) begin
          word.element   = ELEM_MIN;
          word.saturated = 1'b1;
        end else begin
          word.element = rounded[ELEM_W-1:0];
        end
        fresh[r*DIM + c] = word.element;
        pending_products.push_back(word);
      end
    end
    for (int k = 0; k < CELLS; k++) begin
      kept_matrix[k] = fresh[k];
    end
  endtask

  always @(posedge clk) begin
    product_word_t got;
    product_word_t want;
    if (!rst_n) begin
      for (int k = 0; k < CELLS; k++) begin
        kept_matrix[k] = (k % (DIM + 1) == 0) ? (32'sd1 <<< FRAC) : 32'sd0;
      end
      rotor_count = 0;
      pending_products.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.element   = out_tdata;
        got.index     = out_tuser[IDX_W-1:0];
        got.saturated = out_tuser[IDX_W];
        got.last      = out_tlast;
        if (pending_products.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected output word: data %h idx %0d last %b sat %b",
                     got.element, got.index, got.last, got.saturated);
          end
        end else begin
          want = pending_products.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("output word mismatch: expected data %h idx %0d last %b sat %b",
                       want.element, want.index, want.last, want.saturated);
              $display("                      got      data %h idx %0d last %b sat %b",
                       got.element, got.index, got.last, got.saturated);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        rotor_matrix[rotor_count] = in_tdata;
        if (rotor_count == CELLS - 1) begin
          rebuild_kept_matrix();
          rotor_count = 0;
        end else begin
          rotor_count++;
        end
      end
    end
    outstanding = pending_products.size();
  end

endmodule : mma_product_checker

// ----- tb/matrix_4x4_multiply_accumulate_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_4x4_multiply_accumulate_core_tb: stream test of the running product
// Feeds two hand-built rotor matrices that hit the element extremes, rounding
// ties and both saturation directions, then a run of random matrices (small,
// near-identity and full-range) and a trailing partial load. The input side
// sends in bursts with random gaps; the output side stalls in shifting modes.
// ----------------------------------------------------------------------------
module matrix_4x4_multiply_accumulate_core_tb;
  import mma_pkg::*;

  localparam int CELLS       = 16;
  localparam int DIM         = 4;
  localparam int RANDOM_MATS = 12;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [ELEM_W-1:0] ONE      = 32'h0800_0000;
  localparam logic [ELEM_W-1:0] NEG_ONE  = 32'hF800_0000;
  localparam logic [ELEM_W-1:0] HALF     = 32'h0400_0000;
  localparam logic [ELEM_W-1:0] NEG_HALF = 32'hFC00_0000;
  localparam logic [ELEM_W-1:0] ONE_HALF = 32'h0C00_0000;
  localparam logic [ELEM_W-1:0] NEG_1P5  = 32'hF400_0000;
  localparam logic [ELEM_W-1:0] MINUS_1  = 32'hFFFF_FFFF;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [ELEM_W-1:0] in_tdata;   // [31:0] rotor_element
  logic              out_tvalid;
  logic              out_tready;
  logic [ELEM_W-1:0] out_tdata;  // [31:0] product_element
  logic [USER_W-1:0] out_tuser;  // [3:0] element_index, [4] saturated
  logic              out_tlast;

  int                mismatch_count;
  int                outstanding;
  int                cycle_count = 0;
  int                burst_left  = 0;
  bit                no_gaps     = 1'b0;
  logic [ELEM_W-1:0] rotor [CELLS];

  matrix_4x4_multiply_accumulate_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  mma_product_checker u_product_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_rotor_word(input logic [ELEM_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : (($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                        : $urandom_range(0, 4));
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    burst_left--;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_rotor_matrix();
    for (int k = 0; k < CELLS; k++) begin
      send_rotor_word(rotor[k]);
    end
  endtask

  // Output-side stall pattern: the mode is redrawn at random during the run
  initial begin
    int  mode;
    int  mode_cycles;
    int  hold_left;
    bit  level;
    out_tready  = 1'b0;
    mode        = 0;
    mode_cycles = 0;
    hold_left   = 0;
    level       = 1'b0;
    forever begin
      @(negedge clk);
      mode_cycles++;
      if (mode_cycles == 100) begin
        mode        = $urandom_range(0, 3);
        mode_cycles = 0;
      end
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (hold_left == 0) begin
            hold_left = $urandom_range(1, 12);
            level     = !level;
          end
          hold_left--;
          out_tready <= level;
        end
      endcase
    end
  end

  initial begin
    int style;
    int partial;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Diagonal of extremes with a -1 below it; identity M just copies it in
    rotor = '{ELEM_MAX, 32'h0, 32'h0, 32'h0,
              32'h0, ELEM_MIN, 32'h0, 32'h0,
              32'h0, 32'h0, 32'h1, 32'h0,
              MINUS_1, 32'h0, 32'h0, ONE};
    send_rotor_matrix();

    // Row 0 and 1 saturate both ways, row 2 hits rounding ties, row 3 lands
    // just inside the range limits
    rotor = '{ELEM_MAX, ELEM_MIN, 32'h1, 32'h0000_1000,
              ELEM_MAX, ELEM_MIN, MINUS_1, 32'h0000_7FFF,
              HALF, NEG_HALF, ONE_HALF, NEG_1P5,
              ONE, NEG_ONE, ELEM_MAX, ELEM_MIN};
    send_rotor_matrix();

    for (int m = 0; m < RANDOM_MATS; m++) begin
      style   = $urandom_range(0, 9);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < CELLS; k++) begin
        if (style <= 5) begin
          rotor[k] = $urandom_range(0, 2 * ONE) - ONE;
        end else if (style <= 7) begin
          rotor[k] = ((k % (DIM + 1) == 0) ? ONE : 32'h0)
                     + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        end else begin
          rotor[k] = $urandom;
        end
      end
      send_rotor_matrix();
    end

    // Partial load: these words must not produce any output
    partial = $urandom_range(1, CELLS - 1);
    for (int k = 0; k < partial; k++) begin
      send_rotor_word($urandom);
    end
    in_tvalid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule : matrix_4x4_multiply_accumulate_core_tb
